// File: hdl/mdef_pkg.sv
// Package for the maze dead-end filler: item mode codes, wall bit codes,
// controller state type and the command/status structs between the controller and datapath.
// No dependencies.
package mdef_pkg;

  // Item mode codes (mode 3 is treated as a read)
  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_CLOSE = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // Wall bits: north is row-1, east is column+1, south is row+1, west is column-1
  localparam logic [3:0] WALL_N    = 4'b0001;
  localparam logic [3:0] WALL_E    = 4'b0010;
  localparam logic [3:0] WALL_S    = 4'b0100;
  localparam logic [3:0] WALL_W    = 4'b1000;
  localparam logic [3:0] WALLS_ALL = 4'b1111;

  localparam logic [2:0] DEAD_END_WALLS = 3'd3;
  localparam logic [8:0] CLOSED_MAX     = 9'd511;

  // Neighbour visit order while closing a cell
  localparam logic [1:0] NB_NORTH = 2'd0;
  localparam logic [1:0] NB_EAST  = 2'd1;
  localparam logic [1:0] NB_SOUTH = 2'd2;
  localparam logic [1:0] NB_WEST  = 2'd3;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_LOAD,
    ST_READ,
    ST_FIN,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_NB_RD,
    ST_NB_WR
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic clr_wr;
    logic accept;
    logic load_wr;
    logic rd_item;
    logic rd_scan;
    logic scan_next;
    logic close_self;
    logic rd_nb;
    logic wr_nb;
    logic nb_next;
    logic scan_restart;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic       clr_last;
    logic [1:0] mode;
    logic       dead_end;
    logic       scan_last;
    logic       nb_exists;
    logic       nb_last;
    logic       out_free;
  } sts_t;

  function automatic logic [2:0] count_walls(input logic [3:0] w);
    count_walls = {2'b00, w[0]} + {2'b00, w[1]} + {2'b00, w[2]} + {2'b00, w[3]};
  endfunction

endpackage

// File: hdl/maze_dead_end_filler_top.sv
// Top level of the maze dead-end filler: joins the controller and the datapath.
// Depends on mdef_pkg, mdef_ctrl and mdef_dp.
//
// The block holds a ROWS x COLS grid of cells with four wall bits each and
// handles one item at a time. After reset it clears the store in a pass over
// every cell with in_stall high. A read item reads its cell; a load item writes
// its cell, if it lies in the grid, and then reads it back; the next item is
// taken once the result is in the output register. A close item scans cells in
// row-major order through the single-port wall store; each dead end found is
// closed and each of its neighbours in the grid gains the matching wall, after
// which the scan resumes one row above the closed cell, or at the start of the
// top row. A result is held in an output register until taken.
module maze_dead_end_filler_top
  import mdef_pkg::*;
#(
  parameter int ROWS = 16,
  parameter int COLS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_mode,
  input  logic [3:0] in_cell_x,
  input  logic [3:0] in_cell_y,
  input  logic [3:0] in_walls_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_walls_out,
  output logic [2:0] out_wall_count,
  output logic [8:0] out_cells_closed
);

  cmd_t cmd;
  sts_t sts;

  mdef_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  mdef_dp #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_mode          (in_mode),
    .in_cell_x        (in_cell_x),
    .in_cell_y        (in_cell_y),
    .in_walls_in      (in_walls_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_walls_out    (out_walls_out),
    .out_wall_count   (out_wall_count),
    .out_cells_closed (out_cells_closed),
    .cmd              (cmd),
    .sts              (sts)
  );

endmodule

// File: hdl/mdef_ctrl.sv
// Controller of the maze dead-end filler: sequences the clear pass, loads, reads
// and the dead-end scan/close loop. Depends on mdef_pkg.
module mdef_ctrl
  import mdef_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        case (sts.mode)
          MODE_LOAD:  state_nxt = ST_LOAD;
          MODE_CLOSE: state_nxt = ST_SCAN_RD;
          default:    state_nxt = ST_READ;
        endcase
      end
      ST_LOAD:     state_nxt = ST_READ;
      ST_READ:     state_nxt = ST_FIN;
      ST_FIN: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      ST_SCAN_RD:  state_nxt = ST_SCAN_CHK;
      ST_SCAN_CHK: begin
        if (sts.dead_end) state_nxt = ST_NB_RD;
        else if (sts.scan_last) state_nxt = ST_READ;
        else state_nxt = ST_SCAN_RD;
      end
      ST_NB_RD: begin
        if (sts.nb_exists) state_nxt = ST_NB_WR;
        else if (sts.nb_last) state_nxt = ST_SCAN_RD;
        else state_nxt = ST_NB_RD;
      end
      ST_NB_WR: begin
        if (sts.nb_last) state_nxt = ST_SCAN_RD;
        else state_nxt = ST_NB_RD;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_stall = (state_r != ST_IDLE);
    case (state_r)
      ST_CLEAR:    cmd.clr_wr = 1'b1;
      ST_IDLE:     cmd.accept = in_valid;
      ST_LOAD:     cmd.load_wr = 1'b1;
      ST_READ:     cmd.rd_item = 1'b1;
      ST_FIN:      cmd.out_load = sts.out_free;
      ST_SCAN_RD:  cmd.rd_scan = 1'b1;
      ST_SCAN_CHK: begin
        cmd.close_self = sts.dead_end;
        cmd.scan_next  = !sts.dead_end && !sts.scan_last;
      end
      ST_NB_RD: begin
        cmd.rd_nb        = sts.nb_exists;
        cmd.scan_restart = !sts.nb_exists && sts.nb_last;
        cmd.nb_next      = !sts.nb_exists && !sts.nb_last;
      end
      ST_NB_WR: begin
        cmd.wr_nb        = 1'b1;
        cmd.scan_restart = sts.nb_last;
        cmd.nb_next      = !sts.nb_last;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// File: hdl/mdef_dp.sv
// Datapath of the maze dead-end filler: cell wall store, item registers, scan
// and neighbour counters, closed-cell count and the output register. Depends on mdef_pkg.
module mdef_dp
  import mdef_pkg::*;
#(
  parameter int ROWS = 16,
  parameter int COLS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] in_mode,
  input  logic [3:0] in_cell_x,
  input  logic [3:0] in_cell_y,
  input  logic [3:0] in_walls_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_walls_out,
  output logic [2:0] out_wall_count,
  output logic [8:0] out_cells_closed,
  input  cmd_t       cmd,
  output sts_t       sts
);

  localparam int DEPTH = ROWS * COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLS);

  logic [3:0]    mem [DEPTH];
  logic [3:0]    rdata_r;
  logic [AW-1:0] clr_r;
  logic [1:0]    mode_r;
  logic          inside_r;
  logic [RW-1:0] item_row_r;
  logic [CW-1:0] item_col_r;
  logic [3:0]    walls_r;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [1:0]    nb_r;
  logic [8:0]    closed_r;
  logic          out_valid_r;
  logic [3:0]    out_walls_r;
  logic [2:0]    out_count_r;
  logic [8:0]    out_closed_r;

  logic          in_grid;
  logic [AW-1:0] item_addr, scan_addr, nb_addr;
  logic [3:0]    nb_bit;
  logic          nb_exists;
  logic          mouse_hit;
  logic          we;
  logic [AW-1:0] waddr;
  logic [3:0]    wdata;
  logic          re;
  logic [AW-1:0] raddr;
  logic [3:0]    item_walls;

  assign in_grid = (32'(in_cell_x) < COLS) && (32'(in_cell_y) < ROWS);

  // Flat addresses, row-major
  assign item_addr = AW'(item_row_r) * AW'(COLS) + AW'(item_col_r);
  assign scan_addr = AW'(row_r) * AW'(COLS) + AW'(col_r);

  // Neighbour address, the wall it gains and whether it lies in the grid
  always_comb begin
    case (nb_r)
      NB_NORTH: begin
        nb_addr   = scan_addr - AW'(COLS);
        nb_bit    = WALL_S;
        nb_exists = (row_r != '0);
      end
      NB_EAST: begin
        nb_addr   = scan_addr + AW'(1);
        nb_bit    = WALL_W;
        nb_exists = (col_r != CW'(COLS - 1));
      end
      NB_SOUTH: begin
        nb_addr   = scan_addr + AW'(COLS);
        nb_bit    = WALL_N;
        nb_exists = (row_r != RW'(ROWS - 1));
      end
      default: begin
        nb_addr   = scan_addr - AW'(1);
        nb_bit    = WALL_E;
        nb_exists = (col_r != '0);
      end
    endcase
  end

  assign mouse_hit = inside_r && (row_r == item_row_r) && (col_r == item_col_r);

  // Write port select
  always_comb begin
    we    = 1'b0;
    waddr = clr_r;
    wdata = '0;
    if (cmd.clr_wr) begin
      we = 1'b1;
    end else if (cmd.load_wr && inside_r) begin
      we    = 1'b1;
      waddr = item_addr;
      wdata = walls_r;
    end else if (cmd.close_self) begin
      we    = 1'b1;
      waddr = scan_addr;
      wdata = WALLS_ALL;
    end else if (cmd.wr_nb) begin
      we    = 1'b1;
      waddr = nb_addr;
      wdata = rdata_r | nb_bit;
    end
  end

  // Read port select
  always_comb begin
    re    = cmd.rd_item || cmd.rd_scan || cmd.rd_nb;
    raddr = item_addr;
    if (cmd.rd_scan) raddr = scan_addr;
    else if (cmd.rd_nb) raddr = nb_addr;
  end

  // Cell wall store, registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  // Clear sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_r <= clr_r + AW'(1);
    end
  end

  // Item registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r     <= in_mode;
      inside_r   <= in_grid;
      item_row_r <= RW'(in_cell_y);
      item_col_r <= CW'(in_cell_x);
      walls_r    <= in_walls_in;
    end
  end

  // Scan position: clear on accept, advance, or step back one row after a close (to column 0 on the top row)
  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (cmd.accept) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (cmd.scan_next) begin
      if (col_r == CW'(COLS - 1)) begin
        col_nxt = '0;
        row_nxt = row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end else if (cmd.scan_restart) begin
      if (row_r != '0) begin
        row_nxt = row_r - RW'(1);
      end else begin
        col_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    row_r <= row_nxt;
    col_r <= col_nxt;
  end

  // Neighbour counter and closed-cell count
  always_ff @(posedge clk) begin
    if (cmd.close_self) nb_r <= NB_NORTH;
    else if (cmd.nb_next) nb_r <= nb_r + 2'd1;
    if (cmd.accept) closed_r <= '0;
    else if (cmd.close_self && closed_r != CLOSED_MAX) closed_r <= closed_r + 9'd1;
  end

  // Output register
  assign item_walls = inside_r ? rdata_r : 4'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_walls_r  <= item_walls;
      out_count_r  <= count_walls(item_walls);
      out_closed_r <= closed_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_walls_out    = out_walls_r;
  assign out_wall_count   = out_count_r;
  assign out_cells_closed = out_closed_r;

  // Status
  assign sts.clr_last  = (clr_r == AW'(DEPTH - 1));
  assign sts.mode      = mode_r;
  assign sts.dead_end  = (count_walls(rdata_r) == DEAD_END_WALLS) && !mouse_hit;
  assign sts.scan_last = (row_r == RW'(ROWS - 1)) && (col_r == CW'(COLS - 1));
  assign sts.nb_exists = nb_exists;
  assign sts.nb_last   = (nb_r == NB_WEST);
  assign sts.out_free  = !out_valid_r || !out_stall;

endmodule

// File: hdl/mdef_checker.sv
// Port-level checks for the maze dead-end filler, bound to the top level.
// Depends on maze_dead_end_filler_top.
module mdef_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] out_walls_out,
  input logic [2:0] out_wall_count,
  input logic [8:0] out_cells_closed
);

  // Clear pass holds off items straight after reset
  a_stall_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("in_stall low straight after reset");

  // One item at a time: an accepted item stalls the input next cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after an item was accepted");

  // Wall count agrees with the wall bits
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_wall_count} == 4'($countones(out_walls_out))))
    else $error("wall count does not match wall bits");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_walls_out)
      && $stable(out_wall_count) && $stable(out_cells_closed))
    else $error("stalled result changed");

endmodule

bind maze_dead_end_filler_top mdef_checker u_mdef_checker (.*);

// File: dv/maze_dead_end_filler_tb.sv
// Testbench for maze_dead_end_filler_top: directed and random load, read and close items,
// with each result checked against a grid model kept in the bench.
// Depends on mdef_pkg and the maze_dead_end_filler_top RTL.
`timescale 1ns / 100ps

module tb;
  import mdef_pkg::*;

  localparam int ROWS = 16;
  localparam int COLS = 16;
  localparam logic [1:0] MODE_SPARE = 2'd3;  // unused code, behaves as a read
  localparam int RANDOM_ITEMS = 120;
  localparam int QUIET_TAIL   = 20;
  localparam int DRAIN_CYCLES = 32;
  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    logic [1:0] mode;
    logic [3:0] x;
    logic [3:0] y;
    logic [3:0] walls;
  } cell_op_t;

  typedef struct packed {
    logic [3:0] walls;
    logic [2:0] n_walls;
    logic [8:0] n_closed;
  } cell_result_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] in_mode;
  logic [3:0] in_cell_x;
  logic [3:0] in_cell_y;
  logic [3:0] in_walls_in;
  logic       out_valid;
  logic       out_stall;
  logic [3:0] out_walls_out;
  logic [2:0] out_wall_count;
  logic [8:0] out_cells_closed;

  cell_op_t     pending_ops[$];
  cell_result_t expected_results[$];
  logic [3:0]   maze_walls[ROWS*COLS];

  logic in_taken;
  int   in_gap;
  int   stall_left;
  int   n_items;
  int   n_accepted;
  int   n_loads;
  int   n_closes;
  int   n_reads;
  int   cells_filled;
  int   n_checked;
  int   n_errors;
  int   n_cycles;

  maze_dead_end_filler_top #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_cell_x        (in_cell_x),
    .in_cell_y        (in_cell_y),
    .in_walls_in      (in_walls_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_walls_out    (out_walls_out),
    .out_wall_count   (out_wall_count),
    .out_cells_closed (out_cells_closed)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [2:0] walls_present(input logic [3:0] w);
    return 3'($countones(w));
  endfunction

  // Repeatedly seal the first dead end in row-major order, skipping the mouse cell when asked, until none is left.
  // Neighbours pick up the matching wall, so corridors fill back to a junction.
  function automatic logic [8:0] fill_dead_ends(input bit skip_mouse, input int mr,
                                                input int mc);
    logic [8:0] n_sealed;
    bit         found;
    int         r, c, fr, fc;
    n_sealed = '0;
    fr = 0;
    fc = 0;
    do begin
      found = 1'b0;
      for (r = 0; r < ROWS && !found; r++) begin
        for (c = 0; c < COLS && !found; c++) begin
          if (!(skip_mouse && r == mr && c == mc) &&
              walls_present(maze_walls[r*COLS + c]) == DEAD_END_WALLS) begin
            found = 1'b1;
            fr = r;
            fc = c;
          end
        end
      end
      if (found) begin
        maze_walls[fr*COLS + fc] = WALLS_ALL;
        if (fr > 0)      maze_walls[(fr-1)*COLS + fc] |= WALL_S;
        if (fc < COLS-1) maze_walls[fr*COLS + fc + 1] |= WALL_W;
        if (fr < ROWS-1) maze_walls[(fr+1)*COLS + fc] |= WALL_N;
        if (fc > 0)      maze_walls[fr*COLS + fc - 1] |= WALL_E;
        if (n_sealed != CLOSED_MAX) n_sealed++;
      end
    end while (found);
    return n_sealed;
  endfunction

  function automatic void add_op(input logic [1:0] mode, input int x, input int y,
                                 input logic [3:0] w);
    cell_op_t op;
    op.mode  = mode;
    op.x     = 4'(x);
    op.y     = 4'(y);
    op.walls = w;
    pending_ops.push_back(op);
  endfunction

  // Input side: work out the expected result of each item as it is accepted
  always @(posedge clk) begin : accept_side
    bit           on_grid;
    int           idx;
    logic [8:0]   n_sealed;
    logic [3:0]   cur_walls;
    cell_result_t res;
    if (rst_n && in_valid && !in_stall) begin
      on_grid  = (int'(in_cell_x) < COLS) && (int'(in_cell_y) < ROWS);
      idx      = int'(in_cell_y) * COLS + int'(in_cell_x);
      n_sealed = '0;
      case (in_mode)
        MODE_LOAD: begin
          if (on_grid) maze_walls[idx] = in_walls_in;
          n_loads++;
        end
        MODE_CLOSE: begin
          n_sealed = fill_dead_ends(on_grid, int'(in_cell_y), int'(in_cell_x));
          n_closes++;
          cells_filled += int'(n_sealed);
        end
        default: n_reads++;
      endcase
      cur_walls    = on_grid ? maze_walls[idx] : 4'h0;
      res.walls    = cur_walls;
      res.n_walls  = walls_present(cur_walls);
      res.n_closed = n_sealed;
      expected_results.push_back(res);
      n_accepted++;
      in_taken <= 1'b1;
    end
  end

  // Driver: next item from the queue, with idle bursts until the tail of the run
  always @(negedge clk) begin : drive_side
    cell_op_t op;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      in_taken <= 1'b0;
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap--;
      end else if (pending_ops.size() > QUIET_TAIL && $urandom_range(0, 5) == 0) begin
        in_valid <= 1'b0;
        in_gap = $urandom_range(0, 4);
      end else if (pending_ops.size() > 0) begin
        op = pending_ops.pop_front();
        in_valid    <= 1'b1;
        in_mode     <= op.mode;
        in_cell_x   <= op.x;
        in_cell_y   <= op.y;
        in_walls_in <= op.walls;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure, also in bursts
  always @(negedge clk) begin : stall_side
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (pending_ops.size() > QUIET_TAIL && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 4);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: compare each taken result with the oldest expectation
  always @(posedge clk) begin : check_side
    cell_result_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got.walls    = out_walls_out;
      got.n_walls  = out_wall_count;
      got.n_closed = out_cells_closed;
      n_checked++;
      if (expected_results.size() == 0) begin
        n_errors++;
        if (n_errors <= REPORT_MAX)
          $display("Unexpected result %0d: walls %h count %0d closed %0d",
                   n_checked, got.walls, got.n_walls, got.n_closed);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          n_errors++;
          if (n_errors <= REPORT_MAX)
            $display("Mismatch on result %0d (exp/got): walls %h/%h count %0d/%0d closed %0d/%0d",
                     n_checked, want.walls, got.walls, want.n_walls, got.n_walls,
                     want.n_closed, got.n_closed);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles: %0d of %0d items taken, %0d results outstanding",
               n_cycles, n_accepted, n_items, expected_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int         k, run_len, sx, sy, cx, cy, last_x, last_y, pick;
    bit         vertical;
    logic [3:0] w;
    int         n_directed;

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_mode      = MODE_READ;
    in_cell_x    = '0;
    in_cell_y    = '0;
    in_walls_in  = '0;
    out_stall    = 1'b0;
    in_taken     = 1'b0;
    in_gap       = 0;
    stall_left   = 0;
    n_accepted   = 0;
    n_loads      = 0;
    n_closes     = 0;
    n_reads      = 0;
    cells_filled = 0;
    n_checked    = 0;
    n_errors     = 0;
    n_cycles     = 0;
    foreach (maze_walls[i]) maze_walls[i] = 4'h0;

    // Directed: cleared store, extreme walls, spare mode, empty close
    add_op(MODE_READ, 0, 0, 4'hF);
    add_op(MODE_LOAD, 15, 15, WALLS_ALL);
    add_op(MODE_SPARE, 15, 15, 4'h0);
    add_op(MODE_LOAD, 7, 7, 4'h0);
    add_op(MODE_READ, 7, 7, 4'h0);
    add_op(MODE_CLOSE, 15, 0, 4'h0);
    // corridor along row 2 ending at the mouse: chain fills up to the mouse and stops
    add_op(MODE_LOAD, 0, 2, WALL_N | WALL_S | WALL_W);
    add_op(MODE_LOAD, 1, 2, WALL_N | WALL_S);
    add_op(MODE_LOAD, 2, 2, WALL_N | WALL_S);
    add_op(MODE_LOAD, 3, 2, WALL_N | WALL_S);
    add_op(MODE_CLOSE, 3, 2, 4'h0);
    add_op(MODE_READ, 3, 2, 4'h0);
    // two dead ends facing each other: the second is walled in, not counted
    add_op(MODE_LOAD, 0, 5, WALL_N | WALL_S | WALL_W);
    add_op(MODE_LOAD, 1, 5, WALL_N | WALL_E | WALL_S);
    add_op(MODE_CLOSE, 15, 15, 4'h0);
    add_op(MODE_READ, 1, 5, 4'h0);
    // dead ends on the grid corners, neighbours off the grid are skipped
    add_op(MODE_LOAD, 15, 0, WALL_N | WALL_E | WALL_W);
    add_op(MODE_LOAD, 0, 15, WALL_E | WALL_S | WALL_W);
    add_op(MODE_CLOSE, 0, 0, 4'hA);
    add_op(MODE_READ, 15, 1, 4'h5);
    add_op(MODE_SPARE, 0, 14, 4'h0);
    n_directed = pending_ops.size();

    // Random: mostly short corridors followed by a close, plus loose items
    while (pending_ops.size() < n_directed + RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 6) begin
        run_len  = $urandom_range(2, 6);
        vertical = $urandom_range(0, 1);
        sx       = $urandom_range(0, COLS-1);
        sy       = $urandom_range(0, ROWS-1);
        last_x   = sx;
        last_y   = sy;
        for (k = 0; k < run_len; k++) begin
          cx = vertical ? sx : sx + k;
          cy = vertical ? sy + k : sy;
          if (cx >= COLS || cy >= ROWS) break;
          if (k == 0)
            w = vertical ? (WALLS_ALL ^ WALL_S) : (WALLS_ALL ^ WALL_E);
          else
            w = vertical ? (WALL_E | WALL_W) : (WALL_N | WALL_S);
          // now and then spoil the corridor
          if ($urandom_range(0, 4) == 0) w ^= 4'(1 << $urandom_range(0, 3));
          add_op(MODE_LOAD, cx, cy, w);
          last_x = cx;
          last_y = cy;
        end
        if ($urandom_range(0, 1) == 0)
          add_op(MODE_CLOSE, last_x, last_y, 4'($urandom_range(0, 15)));
        else
          add_op(MODE_CLOSE, $urandom_range(0, COLS-1), $urandom_range(0, ROWS-1),
                 4'($urandom_range(0, 15)));
        add_op(MODE_READ, sx, sy, 4'($urandom_range(0, 15)));
        if ($urandom_range(0, 1) == 0)
          add_op(MODE_SPARE, last_x, last_y, 4'($urandom_range(0, 15)));
      end else begin
        pick = $urandom_range(0, 9);
        add_op(pick < 4 ? MODE_LOAD : pick < 6 ? MODE_READ : pick < 8 ? MODE_SPARE : MODE_CLOSE,
               $urandom_range(0, COLS-1), $urandom_range(0, ROWS-1),
               4'($urandom_range(0, 15)));
      end
    end
    n_items = pending_ops.size();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (n_accepted < n_items) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d items: %0d loads, %0d closes that filled %0d cells, %0d reads",
             n_items, n_loads, n_closes, cells_filled, n_reads);
    $display("Checked %0d results in %0d cycles, %0d errors", n_checked, n_cycles, n_errors);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
